### hw/rtl/swsn_pkg.sv
// Shared types and constants for the sliding-window sender with nak resend.
// No dependencies; imported by the store, the top level and the checker.
package swsn_pkg;

	// Default number of descriptor slots in the ring store
	localparam int STORE_DEPTH_DEF = 64;
	// Largest window honoured, whatever the register holds
	localparam int MAX_WINDOW = 8;
	// Window size register value after reset
	localparam logic [3:0] RESET_WINDOW = 4'd4;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_WINDOW_SIZE = 1'b0;

	// Command opcodes
	localparam logic [1:0] OP_SEND    = 2'd0;
	localparam logic [1:0] OP_ACK     = 2'd1;
	localparam logic [1:0] OP_NAK     = 2'd2;
	localparam logic [1:0] OP_TIMEOUT = 2'd3;

	// Transmit causes
	localparam logic [1:0] CAUSE_NEW     = 2'd0;
	localparam logic [1:0] CAUSE_OPEN    = 2'd1;
	localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;
	localparam logic [1:0] CAUSE_NAK     = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] frame_seq;
		logic [7:0]  frame_len;
		logic [31:0] ack_seq;
	} in_t;

	typedef struct packed {
		logic [5:0]  slot;
		logic [31:0] tx_seq;
		logic [7:0]  tx_len;
		logic [1:0]  cause;
		logic        dropped;
		logic        last;
	} out_t;

	// One frame descriptor as held in the store
	typedef struct packed {
		logic [31:0] seq;
		logic [7:0]  len;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEND,
		ST_SEARCH,
		ST_EMIT
	} state_t;

endpackage

### hw/rtl/swsn_store.sv
// Ring store of frame descriptors: one write port, one registered read port.
// Depends on swsn_pkg for the descriptor type and the default depth.
module swsn_store #(
	parameter int DEPTH = swsn_pkg::STORE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  swsn_pkg::entry_t         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output swsn_pkg::entry_t         rdata
);
	import swsn_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	// Write one descriptor per cycle when we is set
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read every cycle into the output register
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/sliding_window_sender_with_nak_top.sv
// Sliding-window sender. Send: a transfer, if the frame enters the window, comes as busy falls.
// Ack/nak: search one window entry a cycle; a matching ack then transmits the frames entering
// the window, a timeout every frame in the window; one transfer per cycle, the last as busy
// falls. The next command is taken as busy falls.
// Reset clears the window pointers and sets the window size to 4; the store is not cleared.
module sliding_window_sender_with_nak_top #(
	parameter int STORE_DEPTH = swsn_pkg::STORE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  swsn_pkg::in_t               cmd,
	// result channel
	output logic                        res_valid,
	output swsn_pkg::out_t              res,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swsn_pkg::APB_AW-1:0] paddr,
	input  logic [swsn_pkg::APB_DW-1:0] pwdata,
	output logic [swsn_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import swsn_pkg::*;

	localparam int SW = $clog2(STORE_DEPTH);
	localparam int PW = SW + 1;
	localparam logic [PW:0]   POS_MOD_W = (PW+1)'(2 * STORE_DEPTH);
	localparam logic [PW-1:0] DEPTH_W   = PW'(STORE_DEPTH);
	localparam logic [5:0]    MAXW_W    = 6'(MAX_WINDOW);

	// Position arithmetic modulo twice the store depth
	function automatic logic [PW-1:0] pos_add(input logic [PW-1:0] a, input logic [PW-1:0] n);
		logic [PW:0] s;
		s = {1'b0, a} + {1'b0, n};
		if (s >= POS_MOD_W) begin
			s = s - POS_MOD_W;
		end
		return s[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] pos_dist(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW:0] d;
		if (a >= b) begin
			d = {1'b0, a} - {1'b0, b};
		end else begin
			d = {1'b0, a} + POS_MOD_W - {1'b0, b};
		end
		return d[PW-1:0];
	endfunction

	function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
		logic [PW-1:0] t;
		t = (p >= DEPTH_W) ? p - DEPTH_W : p;
		return t[SW-1:0];
	endfunction

	state_t        state_q, state_d;
	in_t           item_q, item_d;
	logic [PW-1:0] begin_q, begin_d;
	logic [PW-1:0] end_q, end_d;
	logic [PW-1:0] tail_q, tail_d;
	logic [PW-1:0] r_q, r_d;
	logic [PW-1:0] hi_q, hi_d;
	logic [PW-1:0] m1_q, m1_d;
	logic [3:0]    win_size_q;
	logic          pend_v_s1, pend_v_d;
	logic [PW-1:0] pend_r_s1, pend_r_d;
	logic [SW-1:0] pend_slot_s1;
	out_t          res_q, res_d;
	logic          res_valid_q, res_valid_d;

	logic [3:0]    w_eff;
	logic [PW-1:0] occ;
	logic [PW-1:0] stored;
	logic          issue;
	logic          hit;
	logic          pend_last;
	logic [PW:0]   reach;
	logic [PW-1:0] new_rel;

	logic          st_we;
	logic [SW-1:0] st_waddr;
	entry_t        st_wdata;
	logic [SW-1:0] st_raddr;
	entry_t        st_rdata;

	logic          cfg_wr;

	swsn_store #(
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	// Clamp the window size to the supported range
	always_comb begin
		if ({2'b00, win_size_q} > MAXW_W) begin
			w_eff = MAXW_W[3:0];
		end else begin
			w_eff = win_size_q;
		end
		if (w_eff == 4'd0) begin
			w_eff = 4'd1;
		end
	end

	assign occ       = pos_dist(end_q, begin_q);
	assign stored    = pos_dist(tail_q, begin_q);
	assign issue     = (r_q < hi_q);
	assign hit       = pend_v_s1 && (st_rdata.seq == item_q.ack_seq);
	assign pend_last = (pend_r_s1 == hi_q - PW'(1));

	// New window end for an ack matching at the pending entry
	always_comb begin
		reach = {1'b0, pend_r_s1} + (PW+1)'(1) + (PW+1)'(w_eff);
		if (reach > {1'b0, stored}) begin
			new_rel = stored;
		end else begin
			new_rel = reach[PW-1:0];
		end
		if (new_rel < occ) begin
			new_rel = occ;
		end
	end

	// Sequencer: next state, store access and result
	always_comb begin
		state_d     = state_q;
		item_d      = item_q;
		begin_d     = begin_q;
		end_d       = end_q;
		tail_d      = tail_q;
		r_d         = r_q;
		hi_d        = hi_q;
		m1_d        = m1_q;
		pend_v_d    = 1'b0;
		pend_r_d    = r_q;
		res_d       = res_q;
		res_valid_d = 1'b0;
		st_we       = 1'b0;
		st_waddr    = slot_of(tail_q);
		st_wdata    = '{seq: item_q.frame_seq, len: item_q.frame_len};
		st_raddr    = slot_of(pos_add(begin_q, r_q));

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_d = cmd;
					r_d    = '0;
					hi_d   = occ;
					case (cmd.opcode) inside
						OP_SEND:         state_d = ST_SEND;
						OP_ACK, OP_NAK:  state_d = ST_SEARCH;
						OP_TIMEOUT:      state_d = ST_EMIT;
						default:         state_d = ST_IDLE;
					endcase
				end
			end

			ST_SEND: begin
				state_d = ST_IDLE;
				if (stored >= DEPTH_W) begin
					// store full: drop with flag
					res_d       = '{slot: '0, tx_seq: item_q.frame_seq, tx_len: item_q.frame_len,
						cause: CAUSE_NEW, dropped: 1'b1, last: 1'b1};
					res_valid_d = 1'b1;
				end else begin
					st_we  = 1'b1;
					tail_d = pos_add(tail_q, PW'(1));
					if ((end_q == tail_q) && (occ < PW'(w_eff))) begin
						res_d       = '{slot: 6'(slot_of(end_q)), tx_seq: item_q.frame_seq,
							tx_len: item_q.frame_len, cause: CAUSE_NEW, dropped: 1'b0,
							last: 1'b1};
						res_valid_d = 1'b1;
						end_d       = pos_add(end_q, PW'(1));
					end
				end
			end

			ST_SEARCH: begin
				// read one entry a cycle, compare the one read last cycle
				if (issue) begin
					pend_v_d = 1'b1;
					r_d      = r_q + PW'(1);
				end
				if (hit) begin
					pend_v_d = 1'b0;
					if (item_q.opcode == OP_NAK) begin
						res_d       = '{slot: 6'(pend_slot_s1), tx_seq: st_rdata.seq,
							tx_len: st_rdata.len, cause: CAUSE_NAK, dropped: 1'b0,
							last: 1'b1};
						res_valid_d = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						m1_d    = pend_r_s1 + PW'(1);
						r_d     = occ;
						hi_d    = new_rel;
						state_d = ST_EMIT;
					end
				end else if (!pend_v_s1 && !issue) begin
					state_d = ST_IDLE;
				end
			end

			ST_EMIT: begin
				// read one entry a cycle, transmit the one read last cycle
				if (issue) begin
					pend_v_d = 1'b1;
					r_d      = r_q + PW'(1);
				end
				if (pend_v_s1) begin
					res_d       = '{slot: 6'(pend_slot_s1), tx_seq: st_rdata.seq,
						tx_len: st_rdata.len,
						cause: (item_q.opcode == OP_ACK) ? CAUSE_OPEN : CAUSE_TIMEOUT,
						dropped: 1'b0, last: pend_last};
					res_valid_d = 1'b1;
				end
				if (!issue && (!pend_v_s1 || pend_last)) begin
					state_d = ST_IDLE;
					if (item_q.opcode == OP_ACK) begin
						end_d   = pos_add(begin_q, hi_q);
						begin_d = pos_add(begin_q, m1_q);
					end
				end
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Window pointers and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q     <= '0;
			end_q       <= '0;
			tail_q      <= '0;
			r_q         <= '0;
			hi_q        <= '0;
			pend_v_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			begin_q     <= begin_d;
			end_q       <= end_d;
			tail_q      <= tail_d;
			r_q         <= r_d;
			hi_q        <= hi_d;
			pend_v_s1   <= pend_v_d;
			res_valid_q <= res_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		item_q       <= item_d;
		m1_q         <= m1_d;
		pend_r_s1    <= pend_r_d;
		pend_slot_s1 <= st_raddr;
		res_q        <= res_d;
	end

	// Configuration register
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[APB_AW-1] == REG_WINDOW_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q <= RESET_WINDOW;
		end else if (cfg_wr) begin
			win_size_q <= pwdata[3:0];
		end
	end

	assign prdata    = (paddr[APB_AW-1] == REG_WINDOW_SIZE)
		? {{(APB_DW-4){1'b0}}, win_size_q} : '0;
	assign pready    = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

### hw/rtl/swsn_checker.sv
// Port-level checks for the sliding-window sender, bound to the top level.
// Depends on swsn_pkg for the result type and cause codes.
module swsn_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           res_valid,
	input swsn_pkg::out_t res
);
	import swsn_pkg::*;

	// An accepted command always makes the block busy in the cycle after it is taken
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// Every result stems from work done while busy
	a_res_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(busy))
		else $error("result transfer without preceding work");

	// Results of one command come back to back up to the last one
	a_res_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |=> res_valid)
		else $error("gap inside a result burst");

	// The last result releases the block
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> !busy)
		else $error("busy held after last result");

	// A drop is a single result of a send
	a_drop_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.dropped |-> res.last && (res.cause == CAUSE_NEW))
		else $error("malformed drop result");

endmodule

bind sliding_window_sender_with_nak_top swsn_checker u_swsn_checker (.*);
